// ===== src/bhd_pkg.sv =====
// Shared types and constants for the button and hat debouncer.
// No dependencies; used by every module under src.
package bhd_pkg;

  localparam int unsigned ButtonLinesDef = 16;  // default number of button lines
  localparam int unsigned ButtonWidth    = 16;  // width of the button level and mask fields
  localparam int unsigned HatLines       = 4;   // up, right, down, left
  localparam int unsigned CountWidth     = 8;   // mismatch counter and sample count width
  localparam int unsigned HatCodeWidth   = 4;

  localparam logic [CountWidth-1:0] SamplesReset = 8'd4;

  // Hat direction codes
  localparam logic [HatCodeWidth-1:0] HatUp        = 4'd0;
  localparam logic [HatCodeWidth-1:0] HatUpRight   = 4'd1;
  localparam logic [HatCodeWidth-1:0] HatRight     = 4'd2;
  localparam logic [HatCodeWidth-1:0] HatDownRight = 4'd3;
  localparam logic [HatCodeWidth-1:0] HatDown      = 4'd4;
  localparam logic [HatCodeWidth-1:0] HatDownLeft  = 4'd5;
  localparam logic [HatCodeWidth-1:0] HatLeft      = 4'd6;
  localparam logic [HatCodeWidth-1:0] HatUpLeft    = 4'd7;
  localparam logic [HatCodeWidth-1:0] HatCentred   = 4'd8;

  // Hat line positions in the level field
  localparam int unsigned HatIdxUp    = 0;
  localparam int unsigned HatIdxRight = 1;
  localparam int unsigned HatIdxDown  = 2;
  localparam int unsigned HatIdxLeft  = 3;

  // Control shared by all lanes
  typedef struct packed {
    logic                  step;     // a sample beat is taken this cycle
    logic [CountWidth-1:0] samples;  // configured sample count
  } lane_ctrl_t;

endpackage

// ===== src/bhd_lane.sv =====
// One debounce lane: mismatch counter and stable pressed bit for a single line.
// Depends on bhd_pkg.
module bhd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bhd_pkg::lane_ctrl_t ctrl_i,
  input  logic                level_n_i,
  output logic                stable_o
);

  logic [bhd_pkg::CountWidth-1:0] count_q, count_d, count_inc;
  logic                           stable_q, stable_d;
  logic                           pressed;

  assign pressed   = ~level_n_i;
  assign count_inc = count_q + {{(bhd_pkg::CountWidth-1){1'b0}}, 1'b1};

  always_comb begin
    count_d  = count_q;
    stable_d = stable_q;
    if (ctrl_i.step) begin
      if (pressed == stable_q) begin
        count_d = '0;
      end else if (count_inc >= ctrl_i.samples) begin
        // enough differing samples: flip and restart
        stable_d = pressed;
        count_d  = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      stable_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      stable_q <= stable_d;
    end
  end

  // state after this beat's update
  assign stable_o = stable_d;

endmodule

// ===== src/bhd_merge.sv =====
// Merge stage: packs lane states into the button mask and encodes the hat direction.
// Depends on bhd_pkg.
module bhd_merge #(
  parameter int unsigned ButtonLines = bhd_pkg::ButtonLinesDef
) (
  input  logic [ButtonLines-1:0]            button_pressed_i,
  input  logic [bhd_pkg::HatLines-1:0]      hat_pressed_i,
  output logic [bhd_pkg::ButtonWidth-1:0]   buttons_stable_o,
  output logic [bhd_pkg::HatCodeWidth-1:0]  hat_direction_o
);

  for (genvar j = 0; j < bhd_pkg::ButtonWidth; j++) begin : g_mask
    if (j < ButtonLines) begin : g_used
      assign buttons_stable_o[j] = button_pressed_i[j];
    end else begin : g_unused
      assign buttons_stable_o[j] = 1'b0;
    end
  end

  logic up, right, down, left;

  // opposite directions cancel
  assign up    = hat_pressed_i[bhd_pkg::HatIdxUp]    & ~hat_pressed_i[bhd_pkg::HatIdxDown];
  assign down  = hat_pressed_i[bhd_pkg::HatIdxDown]  & ~hat_pressed_i[bhd_pkg::HatIdxUp];
  assign right = hat_pressed_i[bhd_pkg::HatIdxRight] & ~hat_pressed_i[bhd_pkg::HatIdxLeft];
  assign left  = hat_pressed_i[bhd_pkg::HatIdxLeft]  & ~hat_pressed_i[bhd_pkg::HatIdxRight];

  always_comb begin
    priority if (up && right) begin
      hat_direction_o = bhd_pkg::HatUpRight;
    end else if (down && right) begin
      hat_direction_o = bhd_pkg::HatDownRight;
    end else if (down && left) begin
      hat_direction_o = bhd_pkg::HatDownLeft;
    end else if (up && left) begin
      hat_direction_o = bhd_pkg::HatUpLeft;
    end else if (up) begin
      hat_direction_o = bhd_pkg::HatUp;
    end else if (right) begin
      hat_direction_o = bhd_pkg::HatRight;
    end else if (down) begin
      hat_direction_o = bhd_pkg::HatDown;
    end else if (left) begin
      hat_direction_o = bhd_pkg::HatLeft;
    end else begin
      hat_direction_o = bhd_pkg::HatCentred;
    end
  end

endmodule

// ===== src/button_and_hat_debouncer_unit.sv =====
// Top level of the button and hat debouncer: lanes, merge stage, output register.
// Depends on bhd_pkg, bhd_lane and bhd_merge.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o   | button_levels_n_i, hat_levels_n_i
//   out     | out_valid_o / out_ready_i | buttons_stable_o, hat_direction_o
//   cfg     | cfg_we_i (no wait)        | cfg_wdata_i (debounce sample count)
//
// Throughput is one beat per cycle unless the output stalls; the result of a
// beat appears in the cycle after it is taken. Every lane does one increment
// and compare on accept; the merge result is captured in the output register.
// in_ready_o drops only while the output register is full and out_ready_i is low.
// Reset clears all counters and stable bits (nothing pressed) and loads a
// sample count of four.
module button_and_hat_debouncer_unit #(
  parameter int unsigned ButtonLines = bhd_pkg::ButtonLinesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bhd_pkg::ButtonWidth-1:0]   button_levels_n_i,
  input  logic [bhd_pkg::HatLines-1:0]      hat_levels_n_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bhd_pkg::ButtonWidth-1:0]   buttons_stable_o,
  output logic [bhd_pkg::HatCodeWidth-1:0]  hat_direction_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bhd_pkg::CountWidth-1:0]    cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Configuration register: consecutive differing samples before a flip
  // ---------------------------------------------------------------------------
  logic [bhd_pkg::CountWidth-1:0] samples_q, samples_d;

  assign samples_d = cfg_we_i ? cfg_wdata_i : samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= bhd_pkg::SamplesReset;
    end else begin
      samples_q <= samples_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a beat whenever the output register is free or draining
  // ---------------------------------------------------------------------------
  logic                out_valid_q, out_valid_d;
  logic                in_fire;
  bhd_pkg::lane_ctrl_t lane_ctrl;

  assign in_ready_o        = ~out_valid_q | out_ready_i;
  assign in_fire           = in_valid_i & in_ready_o;
  assign lane_ctrl.step    = in_fire;
  assign lane_ctrl.samples = samples_q;

  // ---------------------------------------------------------------------------
  // Debounce lanes, one per line. Button lines past the port width read level
  // low, i.e. pressed.
  // ---------------------------------------------------------------------------
  logic [ButtonLines-1:0]       button_stable;
  logic [bhd_pkg::HatLines-1:0] hat_stable;

  for (genvar i = 0; i < ButtonLines; i++) begin : g_button
    logic level_n;
    if (i < bhd_pkg::ButtonWidth) begin : g_pin
      assign level_n = button_levels_n_i[i];
    end else begin : g_tied
      assign level_n = 1'b0;
    end
    bhd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .level_n_i (level_n),
      .stable_o  (button_stable[i])
    );
  end

  for (genvar h = 0; h < bhd_pkg::HatLines; h++) begin : g_hat
    bhd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .level_n_i (hat_levels_n_i[h]),
      .stable_o  (hat_stable[h])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge: mask and hat code from the post-update stable states
  // ---------------------------------------------------------------------------
  logic [bhd_pkg::ButtonWidth-1:0]  merge_buttons;
  logic [bhd_pkg::HatCodeWidth-1:0] merge_hat;

  bhd_merge #(
    .ButtonLines (ButtonLines)
  ) u_merge (
    .button_pressed_i (button_stable),
    .hat_pressed_i    (hat_stable),
    .buttons_stable_o (merge_buttons),
    .hat_direction_o  (merge_hat)
  );

  // ---------------------------------------------------------------------------
  // Output register: load on accept, hold while stalled, drop when taken
  // ---------------------------------------------------------------------------
  logic [bhd_pkg::ButtonWidth-1:0]  buttons_q;
  logic [bhd_pkg::HatCodeWidth-1:0] hat_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buttons_q <= merge_buttons;
      hat_q     <= merge_hat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign buttons_stable_o = buttons_q;
  assign hat_direction_o  = hat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // every accepted beat produces a result in the next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat did not produce a result");

  // a taken result with no new beat behind it leaves the register empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !in_fire) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // hat code stays within the defined directions
  a_hat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hat_direction_o <= bhd_pkg::HatCentred))
    else $error("hat direction code out of range");

  // stable up and down hat lines together never yield a code that points to either of them
  a_hat_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hat_stable[bhd_pkg::HatIdxUp] && hat_stable[bhd_pkg::HatIdxDown])
      |=> (hat_direction_o == bhd_pkg::HatRight || hat_direction_o == bhd_pkg::HatLeft ||
           hat_direction_o == bhd_pkg::HatCentred))
    else $error("up and down held together did not cancel");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for button_and_hat_debouncer_unit: directed and randomized sample
// beats, checked against a per-line debounce predictor kept in this file.
// Depends on bhd_pkg and the RTL under src; reads nothing else.
module testbench;

  localparam int unsigned ErrorsShown = 10;  // mismatches printed in full
  localparam int unsigned IdlePercent = 35;  // chance of an idle cycle per side

  // One debounced result as the block reports it
  typedef struct packed {
    logic [bhd_pkg::ButtonWidth-1:0]  buttons;
    logic [bhd_pkg::HatCodeWidth-1:0] hat;
  } debounced_t;

  // DUT ports
  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [bhd_pkg::ButtonWidth-1:0]  button_levels_n_i;
  logic [bhd_pkg::HatLines-1:0]     hat_levels_n_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [bhd_pkg::ButtonWidth-1:0]  buttons_stable_o;
  logic [bhd_pkg::HatCodeWidth-1:0] hat_direction_o;
  logic                             cfg_we_i;
  logic [bhd_pkg::CountWidth-1:0]   cfg_wdata_i;

  // Predictor state: one mismatch counter and one stable bit per line
  logic [bhd_pkg::CountWidth-1:0] debounce_count_q;
  logic [bhd_pkg::CountWidth-1:0] btn_count [bhd_pkg::ButtonWidth];
  logic                           btn_pressed [bhd_pkg::ButtonWidth];
  logic [bhd_pkg::CountWidth-1:0] hat_count [bhd_pkg::HatLines];
  logic                           hat_pressed [bhd_pkg::HatLines];

  // Results predicted but not yet seen at the output, oldest first
  debounced_t pending_debounced_q [$];

  // Run control and statistics
  bit          src_idles;
  bit          sink_stalls;
  int unsigned sink_hold;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned input_stall_cycles;
  int unsigned count_writes;

  button_and_hat_debouncer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .button_levels_n_i (button_levels_n_i),
    .hat_levels_n_i    (hat_levels_n_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .buttons_stable_o  (buttons_stable_o),
    .hat_direction_o   (hat_direction_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_debounce_state();
    debounce_count_q = bhd_pkg::SamplesReset;
    for (int i = 0; i < bhd_pkg::ButtonWidth; i++) begin
      btn_count[i]   = '0;
      btn_pressed[i] = 1'b0;
    end
    for (int i = 0; i < bhd_pkg::HatLines; i++) begin
      hat_count[i]   = '0;
      hat_pressed[i] = 1'b0;
    end
  endfunction

  // Advance one line by one sample. A count of zero behaves like one, since any
  // incremented count already reaches it.
  function automatic void step_line(inout logic [bhd_pkg::CountWidth-1:0] cnt,
                                    inout logic stable, input logic pressed);
    if (pressed == stable) begin
      cnt = '0;
    end else begin
      cnt = cnt + 1'b1;
      if (cnt >= debounce_count_q) begin
        stable = pressed;
        cnt    = '0;
      end
    end
  endfunction

  // Drop opposite directions held together, then encode what is left
  function automatic logic [bhd_pkg::HatCodeWidth-1:0] hat_code_of();
    logic up, rt, dn, lf;
    up = hat_pressed[bhd_pkg::HatIdxUp];
    rt = hat_pressed[bhd_pkg::HatIdxRight];
    dn = hat_pressed[bhd_pkg::HatIdxDown];
    lf = hat_pressed[bhd_pkg::HatIdxLeft];
    if (up && dn) begin
      up = 1'b0;
      dn = 1'b0;
    end
    if (lf && rt) begin
      lf = 1'b0;
      rt = 1'b0;
    end
    if (up && rt) return bhd_pkg::HatUpRight;
    if (dn && rt) return bhd_pkg::HatDownRight;
    if (dn && lf) return bhd_pkg::HatDownLeft;
    if (up && lf) return bhd_pkg::HatUpLeft;
    if (up) return bhd_pkg::HatUp;
    if (rt) return bhd_pkg::HatRight;
    if (dn) return bhd_pkg::HatDown;
    if (lf) return bhd_pkg::HatLeft;
    return bhd_pkg::HatCentred;
  endfunction

  // Take one sample beat (active-low pins) and return the debounced view after it
  function automatic debounced_t debounce_sample(logic [bhd_pkg::ButtonWidth-1:0] btn_n,
                                                 logic [bhd_pkg::HatLines-1:0] hat_n);
    debounced_t res;
    for (int i = 0; i < bhd_pkg::ButtonWidth; i++) begin
      step_line(btn_count[i], btn_pressed[i], ~btn_n[i]);
      res.buttons[i] = btn_pressed[i];
    end
    for (int i = 0; i < bhd_pkg::HatLines; i++) begin
      step_line(hat_count[i], hat_pressed[i], ~hat_n[i]);
    end
    res.hat = hat_code_of();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check output beats, then predict from input beats taken at this edge.
  // The output beat at an edge always stems from an earlier input beat, so check first.
  // ---------------------------------------------------------------------------

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= ErrorsShown) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin
    debounced_t want;
    debounced_t got;
    if (rst_ni) begin
      if (cfg_we_i) debounce_count_q = cfg_wdata_i;
      if (in_valid_i && !in_ready_o) input_stall_cycles++;
      if (out_valid_o && out_ready_i) begin
        got = '{buttons: buttons_stable_o, hat: hat_direction_o};
        results_checked++;
        if (pending_debounced_q.size() == 0) begin
          note_failure($sformatf("result with no sample pending: buttons %h hat %0d",
                                 got.buttons, got.hat));
        end else begin
          want = pending_debounced_q.pop_front();
          if (got.buttons !== want.buttons || got.hat !== want.hat)
            note_failure($sformatf("result %0d: buttons exp %h got %h, hat exp %0d got %0d",
                                   results_checked, want.buttons, got.buttons,
                                   want.hat, got.hat));
        end
      end
      if (in_valid_i && in_ready_o)
        pending_debounced_q.push_back(debounce_sample(button_levels_n_i, hat_levels_n_i));
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, or a counted hold-off when sink_hold is set
  // ---------------------------------------------------------------------------

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        out_ready_i <= 1'b0;
        sink_hold--;
      end else if (sink_stalls) begin
        out_ready_i <= ($urandom_range(99) >= IdlePercent);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one sample beat, with optional idle cycles in front; return at the accept edge
  task automatic send_sample(input logic [bhd_pkg::ButtonWidth-1:0] btn_n,
                             input logic [bhd_pkg::HatLines-1:0] hat_n);
    while (src_idles && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    button_levels_n_i <= btn_n;
    hat_levels_n_i    <= hat_n;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Step past the current edge so a beat taken there is already queued, then
  // wait until every queued result has been taken
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_debounced_q.size() != 0) @(posedge clk_i);
  endtask

  // Load the sample count while the block is idle; counters carry over
  task automatic write_sample_count(input logic [bhd_pkg::CountWidth-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_writes++;
  endtask

  // Active-low hat pins from the pressed directions
  function automatic logic [bhd_pkg::HatLines-1:0] hat_pins(bit up, bit rt, bit dn, bit lf);
    logic [bhd_pkg::HatLines-1:0] pins;
    pins                       = '1;
    pins[bhd_pkg::HatIdxUp]    = ~up;
    pins[bhd_pkg::HatIdxRight] = ~rt;
    pins[bhd_pkg::HatIdxDown]  = ~dn;
    pins[bhd_pkg::HatIdxLeft]  = ~lf;
    return pins;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default count of four after reset: a short press does not stick, a released
  // beat clears every counter, and four pressed beats in a row flip all lines.
  // With all four hat lines held, both opposite pairs cancel to centred.
  task automatic test_reset_defaults();
    src_idles   = 1'b1;
    sink_stalls = 1'b1;
    send_sample('1, '1);
    repeat (3) send_sample('0, '0);
    send_sample('1, '1);
    repeat (4) send_sample('0, '0);
  endtask

  // Count of one: every beat flips what differs. Walk all eight directions,
  // both cancelling pairs, three lines held, and back to centred, while a single
  // pressed button walks across the low thirteen lines of the mask.
  task automatic test_hat_codes();
    logic [bhd_pkg::HatLines-1:0] walk [13];
    walk = '{hat_pins(1, 0, 0, 0), hat_pins(1, 1, 0, 0), hat_pins(0, 1, 0, 0),
             hat_pins(0, 1, 1, 0), hat_pins(0, 0, 1, 0), hat_pins(0, 0, 1, 1),
             hat_pins(0, 0, 0, 1), hat_pins(1, 0, 0, 1), hat_pins(1, 0, 1, 0),
             hat_pins(0, 1, 0, 1), hat_pins(1, 1, 1, 1), hat_pins(1, 1, 1, 0),
             hat_pins(0, 0, 0, 0)};
    write_sample_count(8'd1);
    for (int k = 0; k < 13; k++)
      send_sample(~(bhd_pkg::ButtonWidth'(1) << k), walk[k]);
  endtask

  // Count of zero behaves like one
  task automatic test_zero_count();
    write_sample_count(8'd0);
    send_sample(16'h5555, hat_pins(1, 0, 0, 0));
    send_sample(16'hAAAA, hat_pins(0, 0, 0, 1));
    send_sample('1, '1);
  endtask

  // Hold off the receiver for a long stretch while beats keep coming, so the
  // output register fills and the input stalls
  task automatic test_backpressure();
    src_idles   = 1'b0;
    sink_stalls = 1'b0;
    write_sample_count(8'd3);
    sink_hold = 48;
    repeat (60) send_sample(bhd_pkg::ButtonWidth'($urandom), bhd_pkg::HatLines'($urandom));
    sink_stalls = 1'b1;
  endtask

  // Switch-like stimulus: pick a new target, hold it for about the sample count
  // so lines land just short of or past the threshold, and bounce now and then
  task automatic test_bouncing_presses(input int unsigned beats,
                                       input logic [bhd_pkg::CountWidth-1:0] count);
    logic [bhd_pkg::ButtonWidth-1:0] btn_target;
    logic [bhd_pkg::HatLines-1:0]    hat_target;
    int unsigned                     hold;
    int unsigned                     lo;
    int unsigned                     sent;
    write_sample_count(count);
    btn_target = '1;
    hat_target = '1;
    sent       = 0;
    lo         = (count > 3) ? count - 3 : 1;
    while (sent < beats) begin
      if ($urandom_range(7) == 0) begin
        btn_target = bhd_pkg::ButtonWidth'($urandom);
        hat_target = bhd_pkg::HatLines'($urandom);
      end else begin
        btn_target ^= bhd_pkg::ButtonWidth'($urandom & $urandom);
        hat_target ^= bhd_pkg::HatLines'($urandom & $urandom);
      end
      hold = $urandom_range(count + 3, lo);
      for (int k = 0; k < hold && sent < beats; k++) begin
        if ($urandom_range(2 * hold) == 0)
          send_sample(btn_target ^ bhd_pkg::ButtonWidth'($urandom & $urandom & $urandom),
                      hat_target ^ bhd_pkg::HatLines'($urandom & $urandom));
        else
          send_sample(btn_target, hat_target);
        sent++;
      end
    end
  endtask

  // Unshaped pin noise, useful at the smallest counts where every beat counts
  task automatic test_line_noise(input int unsigned beats,
                                 input logic [bhd_pkg::CountWidth-1:0] count);
    write_sample_count(count);
    repeat (beats)
      send_sample(bhd_pkg::ButtonWidth'($urandom), bhd_pkg::HatLines'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    button_levels_n_i = '1;
    hat_levels_n_i    = '1;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    src_idles         = 1'b0;
    sink_stalls       = 1'b0;
    sink_hold         = 0;
    clear_debounce_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_hat_codes();
    test_zero_count();
    test_backpressure();

    src_idles   = 1'b1;
    sink_stalls = 1'b1;
    test_bouncing_presses(200, bhd_pkg::CountWidth'($urandom_range(8, 2)));
    test_bouncing_presses(150, bhd_pkg::CountWidth'($urandom_range(8, 2)));
    test_line_noise(150, 8'd1);
    test_line_noise(80, 8'd0);

    // Largest count with both sides running flat out
    src_idles   = 1'b0;
    sink_stalls = 1'b0;
    test_bouncing_presses(520, 8'd255);

    src_idles   = 1'b1;
    sink_stalls = 1'b1;
    test_bouncing_presses(220, bhd_pkg::CountWidth'($urandom_range(40, 9)));

    // Drain, then let any late beat show up before judging
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_debounced_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_debounced_q.size()));

    $display("Sent %0d sample beats across %0d count settings from 0 to 255; checked %0d results.",
             beats_sent, count_writes, results_checked);
    $display("Input held off for %0d cycles by output back-pressure; %0d failures seen.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("** button_and_hat_debouncer_unit: PASSED **");
    end else begin
      $display("** button_and_hat_debouncer_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Timeout: %0d results still pending.", pending_debounced_q.size());
    $display("** button_and_hat_debouncer_unit: FAILED **");
    $finish;
  end

endmodule
